// ===== design/assert_macros.svh =====
// Assertion macros used by the RTL file of the GPIO port register block.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/gpioprb_pkg.sv =====
// Package for the GPIO port register block: register offsets, status codes,
// reset values and beat layout constants. Depends on nothing.
`timescale 1ns / 1ps

package gpioprb_pkg;

    // Register offsets from the configured base address.
    localparam logic [31:0] OFF_CFG_LOW  = 32'h0000_0000;
    localparam logic [31:0] OFF_CFG_HIGH = 32'h0000_0004;
    localparam logic [31:0] OFF_IN_DATA  = 32'h0000_0008;
    localparam logic [31:0] OFF_OUT_DATA = 32'h0000_000C;
    localparam logic [31:0] OFF_SET_CLR  = 32'h0000_0010;
    localparam logic [31:0] OFF_CLR      = 32'h0000_0014;
    localparam logic [31:0] OFF_LOCK     = 32'h0000_0018;

    // Status codes returned with each result beat.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_BAD_OFF  = 2'd2
    } status_t;

    // Access kinds carried in tuser.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // The only accepted access size in bytes.
    localparam logic [3:0] ACCESS_SIZE_WORD = 4'd4;

    // Reset value of both configuration words.
    localparam logic [31:0] CFG_RESET = 32'h4444_4444;

    // Lock write that sets the key bit.
    localparam logic [31:0] LOCK_KEY_WORD = 32'h0001_0000;

    // Beat widths: fields packed from bit 0 up, padded to whole bytes.
    localparam int IN_FIELDS_W  = 32 + 4 + 32 + 16;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 32 + 2 + 16;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

// ===== design/gpio_port_register_block.sv =====
// GPIO port register block: seven 32-bit registers behind a stream of bus accesses.
// Depends on gpioprb_pkg and assert_macros.svh.
`timescale 1ns / 1ps

// The block takes one bus access per input beat and returns one result beat with
// read data, status and the 16 output pin levels after the access. It accepts a new
// access every cycle unless stalled. An accepted access moves through the input
// register and then the result register. Back-pressure on the result side stalls
// the input side only when both the input and the result register hold beats.
// The registers sit at offsets 0x00 to 0x18 from base_address, written through
// cfg_we/cfg_wdata. The user must write it only while no access is in flight;
// the block does not enforce this. Writes to the two configuration words are
// ignored while the lock key bit (bit 16 of the lock word) is set.
`include "assert_macros.svh"

module gpio_port_register_block (
    input  logic        clk,
    input  logic        rst_n,
    // Base address write port.
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // Access beats.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: address[31:0], access_size[3:0], write_data[31:0],
    // pin_levels[15:0], zero padding.
    input  logic [gpioprb_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // tuser: op (0 read, 1 write).
    input  logic        s_axis_tuser,
    // Result beats.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: read_data[31:0], status[1:0], pin_drive[15:0], zero padding.
    output logic [gpioprb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // Configuration and port state.
    logic [31:0] base_address_reg;
    logic [31:0] cfg_low_reg,  cfg_low_next;
    logic [31:0] cfg_high_reg, cfg_high_next;
    logic [15:0] output_bits_reg, output_bits_next;
    logic [16:0] lock_reg, lock_next;

    // Input register.
    logic        in_valid_reg;
    logic        in_op_reg;
    logic [31:0] in_address_reg;
    logic [3:0]  in_size_reg;
    logic [31:0] in_wdata_reg;
    logic [15:0] in_pins_reg;

    // Result register.
    logic                 out_valid_reg;
    logic [31:0]          out_read_data_reg, read_data_next;
    gpioprb_pkg::status_t out_status_reg, status_next;
    logic [15:0]          out_pin_drive_reg;

    logic        advance;
    logic        in_load;
    logic [31:0] offset;

    // The result register advances when a beat waits and it is empty or drained.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(gpioprb_pkg::OUT_TDATA_W - gpioprb_pkg::OUT_FIELDS_W){1'b0}},
                            out_pin_drive_reg, out_status_reg, out_read_data_reg};

    // Base address register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= '0;
        end
        else if (cfg_we)
        begin
            base_address_reg <= cfg_wdata;
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_op_reg      <= s_axis_tuser;
            in_address_reg <= s_axis_tdata[31:0];
            in_size_reg    <= s_axis_tdata[35:32];
            in_wdata_reg   <= s_axis_tdata[67:36];
            in_pins_reg    <= s_axis_tdata[83:68];
        end
    end

    // Decode the access and work out the next register values.
    assign offset = in_address_reg - base_address_reg;

    always_comb
    begin
        cfg_low_next     = cfg_low_reg;
        cfg_high_next    = cfg_high_reg;
        output_bits_next = output_bits_reg;
        lock_next        = lock_reg;
        read_data_next   = '0;
        status_next      = gpioprb_pkg::ST_OK;

        if (in_size_reg != gpioprb_pkg::ACCESS_SIZE_WORD)
        begin
            status_next = gpioprb_pkg::ST_BAD_SIZE;
        end
        else if (in_op_reg == gpioprb_pkg::OP_READ)
        begin
            case (offset)
                gpioprb_pkg::OFF_CFG_LOW:  read_data_next = cfg_low_reg;
                gpioprb_pkg::OFF_CFG_HIGH: read_data_next = cfg_high_reg;
                gpioprb_pkg::OFF_IN_DATA:  read_data_next = {16'b0, in_pins_reg};
                gpioprb_pkg::OFF_OUT_DATA: read_data_next = {16'b0, output_bits_reg};
                gpioprb_pkg::OFF_LOCK:     read_data_next = {15'b0, lock_reg};
                default:                   read_data_next = '0;
            endcase
        end
        else
        begin
            case (offset)
                gpioprb_pkg::OFF_CFG_LOW:
                begin
                    if (!lock_reg[16])
                    begin
                        cfg_low_next = in_wdata_reg;
                    end
                end
                gpioprb_pkg::OFF_CFG_HIGH:
                begin
                    if (!lock_reg[16])
                    begin
                        cfg_high_next = in_wdata_reg;
                    end
                end
                gpioprb_pkg::OFF_IN_DATA:
                begin
                    // Input data is read-only; the write is dropped quietly.
                end
                gpioprb_pkg::OFF_OUT_DATA:
                begin
                    output_bits_next = in_wdata_reg[15:0];
                end
                gpioprb_pkg::OFF_SET_CLR:
                begin
                    // Clear first, then set, so a set wins over a clear.
                    output_bits_next = (output_bits_reg & ~in_wdata_reg[31:16])
                                       | in_wdata_reg[15:0];
                end
                gpioprb_pkg::OFF_CLR:
                begin
                    output_bits_next = output_bits_reg & ~in_wdata_reg[15:0];
                end
                gpioprb_pkg::OFF_LOCK:
                begin
                    if (in_wdata_reg == gpioprb_pkg::LOCK_KEY_WORD)
                    begin
                        lock_next = {1'b1, lock_reg[15:0]};
                    end
                    else if (in_wdata_reg == '0 && lock_reg[16])
                    begin
                        lock_next = {1'b0, lock_reg[15:0]};
                    end
                    else
                    begin
                        lock_next = {lock_reg[16], in_wdata_reg[15:0]};
                    end
                end
                default:
                begin
                    status_next = gpioprb_pkg::ST_BAD_OFF;
                end
            endcase
        end
    end

    // Port state updates as each access moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_low_reg     <= gpioprb_pkg::CFG_RESET;
            cfg_high_reg    <= gpioprb_pkg::CFG_RESET;
            output_bits_reg <= '0;
            lock_reg        <= '0;
        end
        else if (advance)
        begin
            cfg_low_reg     <= cfg_low_next;
            cfg_high_reg    <= cfg_high_next;
            output_bits_reg <= output_bits_next;
            lock_reg        <= lock_next;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_read_data_reg <= read_data_next;
            out_status_reg    <= status_next;
            out_pin_drive_reg <= output_bits_next;
        end
    end

    // Assertions.
    `ASSERT_CLK(a_pin_drive_tracks_state, advance |=> out_pin_drive_reg == output_bits_reg, "result pin_drive differs from output data register")
    `ASSERT_CLK(a_locked_cfg_stable, lock_reg[16] |=> $stable(cfg_low_reg) && $stable(cfg_high_reg), "configuration word changed while locked")
    `ASSERT_CLK(a_bad_size_result, advance && in_size_reg != gpioprb_pkg::ACCESS_SIZE_WORD |=> out_status_reg == gpioprb_pkg::ST_BAD_SIZE && out_read_data_reg == '0, "wrong size access not reported")
    `ASSERT_CLK(a_status_code_valid, m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3, "unused status code on result beat")

endmodule
